// ----- rtl/core/acd_pkg.sv -----
// acd_pkg: types and constants shared by the alarm channel dialer.
// No dependencies; used by acd_chan_unit, acd_dialer and alarm_channel_dialer.
package acd_pkg;

  localparam int unsigned CFG_W    = 10;  // width of each setting register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned SUB_W    = 4;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned LEVELS_W = 16;
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned STATES_W = PHASE_W * MAX_CHANNELS;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 64;

  // setting times are in units of 100 timer ticks
  localparam logic [6:0] TIME_UNIT = 7'd100;
  localparam logic [1:0] LAST_ATTEMPT = 2'd2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECALL   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 10'd2;
  localparam logic [CFG_W-1:0] CALL_RST     = 10'd5;
  localparam logic [CFG_W-1:0] RECALL_RST   = 10'd300;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_LOG      = 3'd2,
    PH_DELAY    = 3'd3,
    PH_REQUEST  = 3'd4,
    PH_RECALL   = 3'd5
  } acd_phase_e;

  typedef enum logic [1:0] {
    DL_IDLE = 2'd0,
    DL_WAIT = 2'd1,
    DL_DIAL = 2'd2
  } acd_dl_e;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_CHAN = 2'd1,
    SQ_DIAL = 2'd2
  } acd_seq_e;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIMER_W-1:0] timer;
    logic               claim;
  } acd_chan_res_t;

  typedef struct packed {
    logic              dial;
    logic [SUB_W-1:0]  sub;
    logic [CHAN_W-1:0] chan;
    logic              busy_set;
    logic              busy_clr;
  } acd_dial_out_t;

endpackage

// ----- rtl/core/acd_chan_unit.sv -----
// acd_chan_unit: shared next-state logic for one alarm channel per cycle.
// Depends on acd_pkg.
module acd_chan_unit (
  input  logic [acd_pkg::PHASE_W-1:0] phase_i,
  input  logic [acd_pkg::TIMER_W-1:0] timer_i,
  input  logic                        high_i,
  input  logic                        tick_i,
  input  logic                        busy_i,
  input  logic [acd_pkg::CFG_W-1:0]   debounce_i,
  input  logic [acd_pkg::CFG_W-1:0]   call_i,
  input  logic [acd_pkg::CFG_W-1:0]   recall_i,
  output acd_pkg::acd_chan_res_t      res_o
);

  logic [acd_pkg::TIMER_W-1:0] ticked;
  logic                        expired;
  logic [acd_pkg::CFG_W-1:0]   setting;
  logic [acd_pkg::TIMER_W:0]   product;
  logic [acd_pkg::TIMER_W-1:0] load_val;
  logic                        load;
  acd_pkg::acd_phase_e         ph;

  assign ph      = acd_pkg::acd_phase_e'(phase_i);
  assign ticked  = (tick_i && timer_i != '0) ? timer_i - 1'b1 : timer_i;
  assign expired = (ticked == '0);

  always_comb begin
    unique case (ph)
      acd_pkg::PH_IDLE: setting = debounce_i;
      acd_pkg::PH_LOG:  setting = call_i;
      default:          setting = recall_i;
    endcase
  end

  // 10 x 7 bit product, saturated to the timer width
  assign product  = 17'(setting) * 17'(acd_pkg::TIME_UNIT);
  assign load_val = product[acd_pkg::TIMER_W] ? '1 : product[acd_pkg::TIMER_W-1:0];

  always_comb begin
    res_o.phase = phase_i;
    res_o.claim = 1'b0;
    load        = 1'b0;
    unique case (ph)
      acd_pkg::PH_IDLE: begin
        if (!high_i) begin
          res_o.phase = acd_pkg::PH_DEBOUNCE;
          load        = 1'b1;
        end
      end
      acd_pkg::PH_DEBOUNCE: begin
        if (high_i)       res_o.phase = acd_pkg::PH_IDLE;
        else if (expired) res_o.phase = acd_pkg::PH_LOG;
      end
      acd_pkg::PH_LOG: begin
        res_o.phase = acd_pkg::PH_DELAY;
        load        = 1'b1;
      end
      acd_pkg::PH_DELAY: begin
        if (high_i)       res_o.phase = acd_pkg::PH_IDLE;
        else if (expired) res_o.phase = acd_pkg::PH_REQUEST;
      end
      acd_pkg::PH_REQUEST: begin
        if (!busy_i) begin
          res_o.phase = acd_pkg::PH_RECALL;
          res_o.claim = 1'b1;
          load        = 1'b1;
        end
      end
      acd_pkg::PH_RECALL: begin
        if (high_i)       res_o.phase = acd_pkg::PH_IDLE;
        else if (expired) res_o.phase = acd_pkg::PH_REQUEST;
      end
      default: res_o.phase = acd_pkg::PH_IDLE;
    endcase
    res_o.timer = load ? load_val : ticked;
  end

endmodule

// ----- rtl/core/acd_dialer.sv -----
// acd_dialer: dialer sequencer walking subscribers and attempts.
// Depends on acd_pkg.
module acd_dialer #(
  parameter int unsigned SUBSCRIBERS = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       claim_i,
  input  logic [acd_pkg::CHAN_W-1:0] claim_chan_i,
  input  logic                       step_i,
  input  logic                       modem_busy_i,
  input  logic                       confirmed_i,
  output acd_pkg::acd_dial_out_t     out_o
);

  acd_pkg::acd_dl_e              phase_q, phase_d;
  logic                          pending_q, pending_d;
  logic [acd_pkg::CHAN_W-1:0]    req_chan_q;
  logic [acd_pkg::SUB_W-1:0]     sub_q, sub_d;
  logic [1:0]                    att_q, att_d;
  logic                          more_subs;

  assign more_subs = ({1'b0, sub_q} + 5'd1) < 5'(SUBSCRIBERS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= acd_pkg::DL_IDLE;
      pending_q  <= 1'b0;
      req_chan_q <= '0;
      sub_q      <= '0;
      att_q      <= '0;
    end else begin
      if (claim_i) begin
        pending_q  <= 1'b1;
        req_chan_q <= claim_chan_i;
      end else if (step_i) begin
        pending_q <= pending_d;
      end
      if (step_i) begin
        phase_q <= phase_d;
        sub_q   <= sub_d;
        att_q   <= att_d;
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    sub_d     = sub_q;
    att_d     = att_q;
    out_o     = '0;
    unique case (phase_q)
      acd_pkg::DL_IDLE: begin
        if (pending_q) begin
          pending_d      = 1'b0;
          sub_d          = '0;
          att_d          = '0;
          out_o.busy_set = 1'b1;
          phase_d        = acd_pkg::DL_WAIT;
        end else begin
          out_o.busy_clr = 1'b1;
        end
      end
      acd_pkg::DL_WAIT: begin
        if (!modem_busy_i)    phase_d = acd_pkg::DL_DIAL;
        else if (confirmed_i) phase_d = acd_pkg::DL_IDLE;
      end
      acd_pkg::DL_DIAL: begin
        out_o.dial = 1'b1;
        out_o.sub  = sub_q;
        out_o.chan = req_chan_q;
        if (att_q < acd_pkg::LAST_ATTEMPT) begin
          att_d   = att_q + 2'd1;
          phase_d = acd_pkg::DL_WAIT;
        end else if (more_subs) begin
          sub_d   = sub_q + 1'b1;
          att_d   = '0;
          phase_d = acd_pkg::DL_WAIT;
        end else begin
          phase_d = acd_pkg::DL_IDLE;
        end
      end
      default: phase_d = acd_pkg::DL_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/alarm_channel_dialer.sv -----
// alarm_channel_dialer: top level, scan sequencer, channel store, settings and result register.
// Depends on acd_pkg, acd_chan_unit and acd_dialer.
// Scans: a new scan is accepted only once the previous one has finished the walk through the
// channels, one per cycle through the single channel update unit, and the dialer step; the
// dialer step waits while the result register is full and not being emptied.
// Reset: asynchronous, active low; all channels idle with zero timers, dialer idle, settings 2/5/300.
module alarm_channel_dialer #(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned SUBSCRIBERS = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // scan input: contact_levels[15:0], modem_busy[16], call_confirmed[17], timer_tick[18]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [acd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // result: dial_request[0], dial_subscriber[4:1], dial_channel[9:5], dialer_busy[10],
  // channel_states[58:11]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [acd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [acd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [acd_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // settings
  logic [acd_pkg::CFG_W-1:0] debounce_q, call_q, recall_q;

  // scan sequencer
  acd_pkg::acd_seq_e          seq_q, seq_d;
  logic [CH_W-1:0]            ch_q;
  logic [acd_pkg::LEVELS_W-1:0] levels_q;
  logic                       modem_q, conf_q, tick_q;
  logic                       busy_q, busy_d;

  // channel store, one entry per channel
  logic [acd_pkg::PHASE_W-1:0] phase_q [CHANNELS];
  logic [acd_pkg::TIMER_W-1:0] timer_q [CHANNELS];

  // result register
  logic                           out_valid_q;
  logic [acd_pkg::OUT_TDATA_W-1:0] out_data_q;

  acd_pkg::acd_chan_res_t     chan_res;
  acd_pkg::acd_dial_out_t     dial_out;
  logic                       in_fire, chan_step, last_ch, commit;
  logic [acd_pkg::STATES_W-1:0] states;

  assign s_axis_tready = (seq_q == acd_pkg::SQ_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign chan_step     = (seq_q == acd_pkg::SQ_CHAN);
  assign last_ch       = (ch_q == CH_W'(CHANNELS - 1));
  // the dialer steps once the result register is free or being emptied
  assign commit        = (seq_q == acd_pkg::SQ_DIAL) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= acd_pkg::DEBOUNCE_RST;
      call_q     <= acd_pkg::CALL_RST;
      recall_q   <= acd_pkg::RECALL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        acd_pkg::REG_DEBOUNCE: debounce_q <= cfg_data_i;
        acd_pkg::REG_CALL:     call_q     <= cfg_data_i;
        acd_pkg::REG_RECALL:   recall_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared channel update unit, fed from the entry under the channel counter
  acd_chan_unit u_chan (
    .phase_i    (phase_q[ch_q]),
    .timer_i    (timer_q[ch_q]),
    .high_i     (levels_q[ch_q]),
    .tick_i     (tick_q),
    .busy_i     (busy_q),
    .debounce_i (debounce_q),
    .call_i     (call_q),
    .recall_i   (recall_q),
    .res_o      (chan_res)
  );

  acd_dialer #(
    .SUBSCRIBERS (SUBSCRIBERS)
  ) u_dialer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .claim_i      (chan_step && chan_res.claim),
    .claim_chan_i (acd_pkg::CHAN_W'({1'b0, ch_q} + 1'b1)),
    .step_i       (commit),
    .modem_busy_i (modem_q),
    .confirmed_i  (conf_q),
    .out_o        (dial_out)
  );

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      acd_pkg::SQ_IDLE: if (in_fire) seq_d = acd_pkg::SQ_CHAN;
      acd_pkg::SQ_CHAN: if (last_ch) seq_d = acd_pkg::SQ_DIAL;
      acd_pkg::SQ_DIAL: if (commit)  seq_d = acd_pkg::SQ_IDLE;
      default:                       seq_d = acd_pkg::SQ_IDLE;
    endcase
  end

  // busy flag: a channel claim sets it, the dialer step may set or clear it
  always_comb begin
    busy_d = busy_q;
    if (chan_step && chan_res.claim) begin
      busy_d = 1'b1;
    end else if (commit) begin
      if (dial_out.busy_set)      busy_d = 1'b1;
      else if (dial_out.busy_clr) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= acd_pkg::SQ_IDLE;
      ch_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      seq_q  <= seq_d;
      busy_q <= busy_d;
      if (in_fire)                   ch_q <= '0;
      else if (chan_step && !last_ch) ch_q <= ch_q + 1'b1;
    end
  end

  // scan fields held for the walk
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      levels_q <= s_axis_tdata[15:0];
      modem_q  <= s_axis_tdata[16];
      conf_q   <= s_axis_tdata[17];
      tick_q   <= s_axis_tdata[18];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i] <= acd_pkg::PH_IDLE;
        timer_q[i] <= '0;
      end
    end else if (chan_step) begin
      phase_q[ch_q] <= chan_res.phase;
      timer_q[ch_q] <= chan_res.timer;
    end
  end

  // phase snapshot; channels above CHANNELS read as idle
  always_comb begin
    states = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      states[i*acd_pkg::PHASE_W +: acd_pkg::PHASE_W] = phase_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {5'd0, states, busy_d, dial_out.chan, dial_out.sub, dial_out.dial};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // a result only appears after the dialer step
  a_valid_from_dial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(seq_q == acd_pkg::SQ_DIAL))
    else $error("result offered without a dialer step");

  // a dial command is only issued while the dialer is marked busy
  a_dial_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[10])
    else $error("dial command with dialer not busy");

  // an accepted scan starts the channel walk at channel 0
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (seq_q == acd_pkg::SQ_CHAN) && (ch_q == '0))
    else $error("channel walk did not start");
`endif

endmodule
